>>> hw/rtl/phist_pkg.sv
package phist_pkg;

    // histogram geometry
    localparam int MAX_BUCKETS = 256;
    localparam int COUNT_BITS  = 20;
    localparam int LEVELS      = 256;

    // bucket addressing
    localparam int BKT_AW    = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int BKT_SLOTS = 1 << BKT_AW;

    // field widths
    localparam int MODE_W   = 2;
    localparam int PIXEL_W  = 17;
    localparam int INDEX_W  = 8;
    localparam int CNT_W    = 9;
    localparam int LOW_W    = 9;
    localparam int HIGH_W   = 10;
    localparam int TOTAL_W  = 20;
    localparam int LVL_W    = 9;
    localparam int WID_W    = 9;
    localparam int RECIP_W  = 10;
    localparam int LIM_W    = 10;
    localparam int CFG_IDX_W = 4;

    // item modes
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_COUNT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_KIND   = 4'd1;

    // reciprocal numerator, 2^RECIP_SHIFT with level < 2^RECIP_SHIFT
    localparam int RECIP_SHIFT = 9;
    localparam int RECIP_ONE   = 1 << RECIP_SHIFT;
    localparam int DIV_STEPS   = 10;

    // geometry after reset
    localparam int RST_CNT   = (LEVELS > MAX_BUCKETS) ? MAX_BUCKETS : LEVELS;
    localparam int RST_WIDTH = (LEVELS + RST_CNT - 1) / RST_CNT;
    localparam int RST_RECIP = RECIP_ONE / RST_WIDTH;
    localparam int RST_LIMIT = RST_CNT * RST_WIDTH;

    // result queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int PEND_W     = 4;

    typedef struct packed {
        logic               busy;
        logic               kind;
        logic [CNT_W-1:0]   cnt;
        logic [WID_W-1:0]   width;
        logic [RECIP_W-1:0] recip;
        logic [LIM_W-1:0]   limit;
    } t_geom;

    typedef struct packed {
        logic               ok;
        logic [TOTAL_W-1:0] total;
        logic [HIGH_W-1:0]  high;
        logic [LOW_W-1:0]   low;
    } t_result;

endpackage

>>> hw/rtl/phist_ram.sv
module phist_ram #(
    parameter int WIDTH  = 8,
    parameter int ADDR_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/phist_cfg.sv
module phist_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr_valid,
    output logic                           o_wr_ready,
    input  logic [phist_pkg::CFG_IDX_W-1:0] i_wr_index,
    input  logic [phist_pkg::CNT_W-1:0]     i_wr_data,
    output phist_pkg::t_geom                o_geom
);

    typedef enum logic [1:0] {ST_IDLE, ST_DIV_W, ST_DIV_M, ST_LIMIT} t_state;

    t_state                          r_state;
    logic                            r_kind;
    logic [phist_pkg::CNT_W-1:0]     r_cnt;
    logic [phist_pkg::WID_W-1:0]     r_width;
    logic [phist_pkg::RECIP_W-1:0]   r_recip;
    logic [phist_pkg::LIM_W-1:0]     r_limit;
    logic [3:0]                      r_step;
    logic [phist_pkg::RECIP_W-1:0]   r_rem;
    logic [phist_pkg::RECIP_W-1:0]   r_quo;
    logic [phist_pkg::WID_W-1:0]     r_den;

    logic [phist_pkg::CNT_W-1:0]     eff;
    logic [phist_pkg::RECIP_W-1:0]   rem_sh;
    logic                            ge;
    logic [phist_pkg::RECIP_W-1:0]   n_rem;
    logic [phist_pkg::RECIP_W-1:0]   n_quo;
    logic                            wr;
    logic                            last_step;

    assign wr        = i_wr_valid && o_wr_ready;
    assign last_step = (r_step == 4'(phist_pkg::DIV_STEPS - 1));

    // clamp the count into 1..MAX_BUCKETS
    always_comb begin
        if (i_wr_data == '0) begin
            eff = phist_pkg::CNT_W'(1);
        end else if (i_wr_data > phist_pkg::CNT_W'(phist_pkg::MAX_BUCKETS)) begin
            eff = phist_pkg::CNT_W'(phist_pkg::MAX_BUCKETS);
        end else begin
            eff = i_wr_data;
        end
    end

    // one restoring division step
    always_comb begin
        rem_sh = {r_rem[phist_pkg::RECIP_W-2:0], r_quo[phist_pkg::RECIP_W-1]};
        ge     = (rem_sh >= {1'b0, r_den});
        n_rem  = ge ? (rem_sh - {1'b0, r_den}) : rem_sh;
        n_quo  = {r_quo[phist_pkg::RECIP_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_kind  <= 1'b1;
            r_cnt   <= phist_pkg::CNT_W'(phist_pkg::RST_CNT);
            r_width <= phist_pkg::WID_W'(phist_pkg::RST_WIDTH);
            r_recip <= phist_pkg::RECIP_W'(phist_pkg::RST_RECIP);
            r_limit <= phist_pkg::LIM_W'(phist_pkg::RST_LIMIT);
            r_step  <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (wr && i_wr_index == phist_pkg::CFG_PIXEL_KIND) begin
                        r_kind <= i_wr_data[0];
                    end
                    if (wr && i_wr_index == phist_pkg::CFG_BUCKET_COUNT) begin
                        // width = floor((255 + c) / c)
                        r_cnt   <= eff;
                        r_rem   <= '0;
                        r_quo   <= phist_pkg::RECIP_W'(phist_pkg::LEVELS - 1)
                                   + phist_pkg::RECIP_W'(eff);
                        r_den   <= eff;
                        r_step  <= '0;
                        r_state <= ST_DIV_W;
                    end
                end
                ST_DIV_W: begin
                    r_rem  <= n_rem;
                    r_quo  <= n_quo;
                    r_step <= r_step + 4'd1;
                    if (last_step) begin
                        // reciprocal = floor(512 / width)
                        r_width <= n_quo[phist_pkg::WID_W-1:0];
                        r_den   <= n_quo[phist_pkg::WID_W-1:0];
                        r_rem   <= '0;
                        r_quo   <= phist_pkg::RECIP_W'(phist_pkg::RECIP_ONE);
                        r_step  <= '0;
                        r_state <= ST_DIV_M;
                    end
                end
                ST_DIV_M: begin
                    r_rem  <= n_rem;
                    r_quo  <= n_quo;
                    r_step <= r_step + 4'd1;
                    if (last_step) begin
                        r_recip <= n_quo;
                        r_state <= ST_LIMIT;
                    end
                end
                ST_LIMIT: begin
                    r_limit <= phist_pkg::LIM_W'(r_cnt * r_width);
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_wr_ready   = (r_state == ST_IDLE);
    assign o_geom.busy  = (r_state != ST_IDLE);
    assign o_geom.kind  = r_kind;
    assign o_geom.cnt   = r_cnt;
    assign o_geom.width = r_width;
    assign o_geom.recip = r_recip;
    assign o_geom.limit = r_limit;

endmodule

>>> hw/rtl/phist_core.sv
module phist_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  phist_pkg::t_geom              i_geom,
    input  logic                          i_take,
    input  logic [phist_pkg::MODE_W-1:0]  i_mode,
    input  logic [phist_pkg::PIXEL_W-1:0] i_pixel,
    input  logic [phist_pkg::INDEX_W-1:0] i_index,
    output logic                          o_push,
    output phist_pkg::t_result            o_res
);

    // stage 1: level and range check
    logic                          r1_vld;
    logic [phist_pkg::MODE_W-1:0]  r1_mode;
    logic                          r1_keep;
    logic [phist_pkg::LVL_W-1:0]   r1_lvl;
    logic [phist_pkg::INDEX_W-1:0] r1_idx;
    // stage 2: estimated bucket
    logic                          r2_vld;
    logic [phist_pkg::MODE_W-1:0]  r2_mode;
    logic                          r2_keep;
    logic [phist_pkg::LVL_W-1:0]   r2_lvl;
    logic [phist_pkg::INDEX_W-1:0] r2_idx;
    logic [phist_pkg::INDEX_W-1:0] r2_qhat;
    // stage 3: bucket address, memory read
    logic                          r3_vld;
    logic [phist_pkg::MODE_W-1:0]  r3_mode;
    logic                          r3_keep;
    logic [phist_pkg::INDEX_W-1:0] r3_addr;
    logic [phist_pkg::LOW_W-1:0]   r3_low;
    logic [phist_pkg::HIGH_W-1:0]  r3_high;
    // stage 4: modify and write back
    logic                          r4_vld;
    logic [phist_pkg::MODE_W-1:0]  r4_mode;
    logic                          r4_keep;
    logic [phist_pkg::INDEX_W-1:0] r4_addr;
    logic [phist_pkg::LOW_W-1:0]   r4_low;
    logic [phist_pkg::HIGH_W-1:0]  r4_high;
    logic                          r4_vbit;

    logic [phist_pkg::BKT_SLOTS-1:0]  r_vbits;
    logic                             r_fwd_vld;
    logic [phist_pkg::INDEX_W-1:0]    r_fwd_addr;
    logic [phist_pkg::COUNT_BITS-1:0] r_fwd_data;

    logic [phist_pkg::PIXEL_W+7:0]    frac;
    logic [phist_pkg::PIXEL_W-1:0]    level;
    logic                             keep;
    logic [18:0]                      p1;
    logic [phist_pkg::INDEX_W-1:0]    opnd;
    logic [16:0]                      p2;
    logic [phist_pkg::LVL_W:0]        rem;
    logic                             corr;
    logic [phist_pkg::INDEX_W-1:0]    bkt;
    logic [phist_pkg::HIGH_W-1:0]     hi;
    logic [phist_pkg::COUNT_BITS-1:0] rd_data;
    logic                             hit;
    logic [phist_pkg::COUNT_BITS-1:0] cur;
    logic                             sat;
    logic [phist_pkg::COUNT_BITS-1:0] nxt;
    logic                             wr;

    // level: integer as is, fraction as floor(v * 255 / 65536)
    always_comb begin
        frac  = {i_pixel, 8'b0} - {8'b0, i_pixel};
        level = i_geom.kind ? i_pixel : {8'b0, frac[phist_pkg::PIXEL_W+7:16]};
        case (i_mode)
            phist_pkg::MODE_ADD:  keep = (level < {7'b0, i_geom.limit});
            phist_pkg::MODE_READ: keep = ({1'b0, i_index} < i_geom.cnt);
            default:              keep = 1'b1;
        endcase
    end

    // estimate with the reciprocal, one short at most
    assign p1 = r1_lvl * i_geom.recip;

    always_comb begin
        opnd = (r2_mode == phist_pkg::MODE_READ) ? r2_idx : r2_qhat;
        p2   = opnd * i_geom.width;
        rem  = {1'b0, r2_lvl} - p2[phist_pkg::LVL_W:0];
        corr = (rem >= {1'b0, i_geom.width});
        bkt  = r2_qhat + phist_pkg::INDEX_W'(corr);
        hi   = p2[phist_pkg::HIGH_W-1:0] + {1'b0, i_geom.width};
    end

    always_ff @(posedge i_clk) begin
        r1_mode <= i_mode;
        r1_keep <= keep;
        r1_lvl  <= level[phist_pkg::LVL_W-1:0];
        r1_idx  <= i_index;

        r2_mode <= r1_mode;
        r2_keep <= r1_keep;
        r2_lvl  <= r1_lvl;
        r2_idx  <= r1_idx;
        r2_qhat <= p1[phist_pkg::RECIP_SHIFT+phist_pkg::INDEX_W-1:phist_pkg::RECIP_SHIFT];

        r3_mode <= r2_mode;
        r3_keep <= r2_keep;
        r3_addr <= (r2_mode == phist_pkg::MODE_READ) ? r2_idx : bkt;
        r3_low  <= p2[phist_pkg::LOW_W-1:0];
        r3_high <= hi;

        r4_mode <= r3_mode;
        r4_keep <= r3_keep;
        r4_addr <= r3_addr;
        r4_low  <= r3_low;
        r4_high <= r3_high;
        r4_vbit <= r_vbits[r3_addr[phist_pkg::BKT_AW-1:0]];

        r_fwd_addr <= r4_addr;
        r_fwd_data <= nxt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r3_vld    <= 1'b0;
            r4_vld    <= 1'b0;
            r_fwd_vld <= 1'b0;
            r_vbits   <= '0;
        end else begin
            r1_vld    <= i_take;
            r2_vld    <= r1_vld;
            r3_vld    <= r2_vld;
            r4_vld    <= r3_vld;
            r_fwd_vld <= wr;
            if (wr) begin
                r_vbits[r4_addr[phist_pkg::BKT_AW-1:0]] <= 1'b1;
            end
            // clear acts at the read stage, later in order than the write above
            if (r3_vld && r3_mode == phist_pkg::MODE_CLEAR) begin
                r_vbits <= '0;
            end
        end
    end

    phist_ram #(
        .WIDTH  (phist_pkg::COUNT_BITS),
        .ADDR_W (phist_pkg::BKT_AW)
    ) u_counts (
        .i_clk   (i_clk),
        .i_we    (wr),
        .i_waddr (r4_addr[phist_pkg::BKT_AW-1:0]),
        .i_wdata (nxt),
        .i_raddr (r3_addr[phist_pkg::BKT_AW-1:0]),
        .o_rdata (rd_data)
    );

    // read-modify-write with forwarding of the previous cycle's write
    always_comb begin
        hit = r_fwd_vld && (r_fwd_addr == r4_addr);
        if (hit) begin
            cur = r_fwd_data;
        end else if (r4_vbit) begin
            cur = rd_data;
        end else begin
            cur = '0;
        end
        sat = &cur;
        nxt = cur + {{(phist_pkg::COUNT_BITS-1){1'b0}}, ~sat};
        wr  = r4_vld && (r4_mode == phist_pkg::MODE_ADD) && r4_keep;
    end

    assign o_push       = r4_vld && (r4_mode == phist_pkg::MODE_READ);
    assign o_res.ok     = r4_keep;
    assign o_res.low    = r4_keep ? r4_low : '0;
    assign o_res.high   = r4_keep ? r4_high : '0;
    assign o_res.total  = r4_keep ? phist_pkg::TOTAL_W'(cur) : '0;

endmodule

>>> hw/rtl/pixel_intensity_histogram_unit.sv
// Intensity histogram over a pixel stream. Every input word carries a mode in
// tuser: clear all counts, add one pixel, or read one bucket; only a read gives
// an output word, in the order the reads were taken. Words are taken at one per
// cycle while the input is not held off, and a read result passes through the
// core pipeline before it waits in an eight-word queue; the input holds off
// when eight reads are outstanding. Counts live in a 256-entry memory with one
// read port and one write port, updated by read-modify-write with forwarding of
// the previous cycle's write, so back-to-back pixels into one bucket count
// correctly. A per-bucket valid bit makes clear and reset take effect at once,
// with no clearing pass. Writing bucket_count starts a recalculation of the
// bucket width, its reciprocal and the covered level range on a shared serial
// divider, during which both the input and the configuration port hold off.
// Writing pixel_kind takes effect at once.
module pixel_intensity_histogram_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [phist_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [phist_pkg::CNT_W-1:0]     i_cfg_data,
    // input words
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [31:0]                     s_axis_tdata,  // pixel_value, bucket_index
    input  logic [phist_pkg::MODE_W-1:0]    s_axis_tuser,  // mode
    // output words
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [39:0]                     m_axis_tdata,  // bucket_low, bucket_high,
                                                           // bucket_total
    output logic                            m_axis_tuser   // index_valid
);

    phist_pkg::t_geom   geom;
    phist_pkg::t_result res;
    logic               push;
    logic               pop;
    logic               take;
    logic               take_read;

    phist_pkg::t_result              r_fifo [phist_pkg::FIFO_DEPTH];
    logic [phist_pkg::FIFO_AW-1:0]   r_wptr;
    logic [phist_pkg::FIFO_AW-1:0]   r_rptr;
    logic [phist_pkg::PEND_W-1:0]    r_fcnt;
    // reads taken whose result has not yet left
    logic [phist_pkg::PEND_W-1:0]    r_pend;

    phist_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_cfg_valid),
        .o_wr_ready (o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_geom     (geom)
    );

    // stall input while the geometry is being recomputed or the queue could overrun
    assign s_axis_tready = !geom.busy
                         && (r_pend < phist_pkg::PEND_W'(phist_pkg::FIFO_DEPTH));
    assign take          = s_axis_tvalid && s_axis_tready;
    assign take_read     = take && (s_axis_tuser == phist_pkg::MODE_READ);

    phist_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_geom  (geom),
        .i_take  (take),
        .i_mode  (s_axis_tuser),
        .i_pixel (s_axis_tdata[phist_pkg::PIXEL_W-1:0]),
        .i_index (s_axis_tdata[phist_pkg::PIXEL_W+phist_pkg::INDEX_W-1:phist_pkg::PIXEL_W]),
        .o_push  (push),
        .o_res   (res)
    );

    // result queue
    assign pop = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wptr] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fcnt <= '0;
            r_pend <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + phist_pkg::FIFO_AW'(1);
            end
            if (pop) begin
                r_rptr <= r_rptr + phist_pkg::FIFO_AW'(1);
            end
            r_fcnt <= r_fcnt + phist_pkg::PEND_W'(push) - phist_pkg::PEND_W'(pop);
            r_pend <= r_pend + phist_pkg::PEND_W'(take_read) - phist_pkg::PEND_W'(pop);
        end
    end

    assign m_axis_tvalid = (r_fcnt != '0);
    assign m_axis_tdata  = {1'b0, r_fifo[r_rptr].total, r_fifo[r_rptr].high,
                            r_fifo[r_rptr].low};
    assign m_axis_tuser  = r_fifo[r_rptr].ok;

`ifndef SYNTH
    // the queue never overruns
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |-> (r_fcnt < phist_pkg::PEND_W'(phist_pkg::FIFO_DEPTH)))
        else $error("result queue overrun");

    // every queued result belongs to an outstanding read
    a_pend_cover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fcnt <= r_pend)
        else $error("queued results exceed outstanding reads");

    // a read of a bucket beyond the bucket count reports all-zero bounds and count
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("invalid read carries non-zero fields");

    // a bucket count write starts the geometry recalculation
    a_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready && i_cfg_index == phist_pkg::CFG_BUCKET_COUNT)
        |=> (geom.busy && !s_axis_tready))
        else $error("bucket count write did not hold off input");
`endif

endmodule
